@@ rtl/vegl_pkg.sv @@
// Shared types and constants for the volume event generation lease checker.
`timescale 1ns / 1ps

package vegl_pkg;

  // Log depth: once this many events are accepted, every event reports full.
  localparam int LOG_CAPACITY = 256;

  localparam int GEN_W   = 64;
  localparam int LEASE_W = 64;
  localparam int SEQ_W   = 9;

  localparam logic [6:0] PERCENT_MAX = 7'd100;
  localparam logic [7:0] VOLUME_MAX  = 8'd127;

  typedef enum logic [2:0] {
    KIND_START         = 3'd0,
    KIND_END           = 3'd1,
    KIND_CAPABILITY    = 3'd2,
    KIND_HOST_VOLUME   = 3'd3,
    KIND_DEVICE_VOLUME = 3'd4,
    KIND_LEASE_ACQUIRE = 3'd5,
    KIND_LEASE_REVOKE  = 3'd6,
    KIND_MODE          = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED           = 3'd0,
    ST_INVALID_ARGUMENT   = 3'd1,
    ST_INVALID_ENUM       = 3'd2,
    ST_OUT_OF_RANGE       = 3'd3,
    ST_STALE              = 3'd4,
    ST_INVALID_TRANSITION = 3'd5,
    ST_FULL               = 3'd6
  } status_t;

  localparam logic [1:0] SUPPORT_INVALID = 2'd3;

  typedef struct packed {
    kind_t                kind;
    logic [GEN_W-1:0]     generation;
    logic [1:0]           support;
    logic [1:0]           device_event;
    logic [1:0]           gate_mode;
    logic [6:0]           host_percent;
    logic [7:0]           device_volume;
    logic [LEASE_W-1:0]   lease_id;
  } event_t;

  typedef struct packed {
    status_t              status;
    logic [SEQ_W-1:0]     assigned_sequence;
    logic                 active_now;
    logic [LEASE_W-1:0]   lease_now;
  } result_t;

endpackage

@@ rtl/volume_event_generation_lease_checker.sv @@
// Top level of the volume event generation and lease checker.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in_     | input     | in_valid/in_stall  | kind, generation, support, device_event,
//           |           |                    | gate_mode, host_percent, device_volume,
//           |           |                    | lease_id
//   out_    | output    | out_valid/out_stall| status, assigned_sequence, active_now,
//           |           |                    | lease_now
//
// One request per cycle sustained while out_stall stays low; out_valid rises
// once the accepted request has passed the input register, then the result register.
// Checks and state update happen in one pass between the two registers; the
// state commits when the request moves into the result register, so the
// following request already sees the updated generation, lease and count.
// rst_n is synchronous, active low; it clears all state and both valid flags.
// out_stall holds the result register; the input register keeps taking a
// request whenever its content moves on in the same cycle.
`timescale 1ns / 1ps

module volume_event_generation_lease_checker (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_generation,
  input  logic [1:0]  in_support,
  input  logic [1:0]  in_device_event,
  input  logic [1:0]  in_gate_mode,
  input  logic [6:0]  in_host_percent,
  input  logic [7:0]  in_device_volume,
  input  logic [63:0] in_lease_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [8:0]  out_assigned_sequence,
  output logic        out_active_now,
  output logic [63:0] out_lease_now
);

  vegl_pkg::event_t  in_evt;
  vegl_pkg::event_t  s1_evt;
  vegl_pkg::result_t core_res;
  vegl_pkg::result_t out_res;
  logic              s1_valid;
  logic              s1_take;
  logic              load_ready;

  // pack the request fields
  assign in_evt.kind          = vegl_pkg::kind_t'(in_kind);
  assign in_evt.generation    = in_generation;
  assign in_evt.support       = in_support;
  assign in_evt.device_event  = in_device_event;
  assign in_evt.gate_mode     = in_gate_mode;
  assign in_evt.host_percent  = in_host_percent;
  assign in_evt.device_volume = in_device_volume;
  assign in_evt.lease_id      = in_lease_id;

  // request moves on (and state commits) when the result register can load
  assign s1_take = s1_valid & load_ready;

  vegl_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_evt   (in_evt),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_evt   (s1_evt)
  );

  vegl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_take),
    .evt    (s1_evt),
    .res    (core_res)
  );

  vegl_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid),
    .load_ready (load_ready),
    .load_res   (core_res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // unpack the result fields
  assign out_status            = out_res.status;
  assign out_assigned_sequence = out_res.assigned_sequence;
  assign out_active_now        = out_res.active_now;
  assign out_lease_now         = out_res.lease_now;

endmodule

@@ rtl/vegl_in_reg.sv @@
// Input register stage holding one event request.
`timescale 1ns / 1ps

module vegl_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vegl_pkg::event_t in_evt,
  output logic            s1_valid,
  input  logic            s1_take,
  output vegl_pkg::event_t s1_evt
);

  logic             valid_r, valid_nxt;
  vegl_pkg::event_t evt_r;
  logic             accept;

  assign in_stall = valid_r & ~s1_take;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt_r <= in_evt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_evt   = evt_r;

endmodule

@@ rtl/vegl_core.sv @@
// Event checks and generation / lease state.
`timescale 1ns / 1ps

module vegl_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  vegl_pkg::event_t evt,
  output vegl_pkg::result_t res
);

  logic [vegl_pkg::GEN_W-1:0]   latest_gen_r, latest_gen_nxt;
  logic                         active_r, active_nxt;
  logic [vegl_pkg::LEASE_W-1:0] lease_r, lease_nxt;
  logic [vegl_pkg::SEQ_W-1:0]   count_r, count_nxt;

  logic [vegl_pkg::GEN_W-1:0]   gen_delta;
  logic                         newer;
  logic                         full;
  logic                         bad_enum;
  logic                         bad_range;
  vegl_pkg::status_t            status;

  // serial-number compare; any nonzero generation beats an empty history
  assign gen_delta = evt.generation - latest_gen_r;
  assign newer     = (latest_gen_r == '0) ||
                     ((gen_delta != '0) && !gen_delta[vegl_pkg::GEN_W-1]);

  assign full      = (32'(count_r) >= 32'(vegl_pkg::LOG_CAPACITY));
  assign bad_enum  = (evt.support == vegl_pkg::SUPPORT_INVALID) ||
                     evt.device_event[1] || evt.gate_mode[1];
  assign bad_range = (evt.host_percent > vegl_pkg::PERCENT_MAX) ||
                     (evt.device_volume > vegl_pkg::VOLUME_MAX);

  always_comb begin
    latest_gen_nxt = latest_gen_r;
    active_nxt     = active_r;
    lease_nxt      = lease_r;
    status         = vegl_pkg::ST_ACCEPTED;
    if (full) begin
      status = vegl_pkg::ST_FULL;
    end else if (evt.generation == '0) begin
      status = vegl_pkg::ST_INVALID_ARGUMENT;
    end else if (bad_enum) begin
      status = vegl_pkg::ST_INVALID_ENUM;
    end else if (bad_range) begin
      status = vegl_pkg::ST_OUT_OF_RANGE;
    end else if (evt.kind == vegl_pkg::KIND_START) begin
      if (!newer) begin
        status = vegl_pkg::ST_STALE;
      end else begin
        latest_gen_nxt = evt.generation;
        active_nxt     = 1'b1;
        lease_nxt      = '0;
      end
    end else if (!active_r || (evt.generation != latest_gen_r)) begin
      status = vegl_pkg::ST_STALE;
    end else begin
      unique case (evt.kind)
        vegl_pkg::KIND_END: begin
          active_nxt = 1'b0;
          lease_nxt  = '0;
        end
        vegl_pkg::KIND_LEASE_ACQUIRE: begin
          if (evt.lease_id == '0) begin
            status = vegl_pkg::ST_OUT_OF_RANGE;
          end else if ((lease_r != '0) && (lease_r != evt.lease_id)) begin
            status = vegl_pkg::ST_INVALID_TRANSITION;
          end else begin
            lease_nxt = evt.lease_id;
          end
        end
        vegl_pkg::KIND_LEASE_REVOKE: begin
          if (evt.lease_id == '0) begin
            status = vegl_pkg::ST_OUT_OF_RANGE;
          end else if (lease_r != evt.lease_id) begin
            status = vegl_pkg::ST_INVALID_TRANSITION;
          end else begin
            lease_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    count_nxt = (status == vegl_pkg::ST_ACCEPTED) ? count_r + 1'b1 : count_r;
  end

  assign res.status            = status;
  assign res.assigned_sequence = (status == vegl_pkg::ST_ACCEPTED) ? count_nxt : '0;
  assign res.active_now        = active_nxt;
  assign res.lease_now         = lease_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_gen_r <= '0;
      active_r     <= 1'b0;
      lease_r      <= '0;
      count_r      <= '0;
    end else if (commit) begin
      latest_gen_r <= latest_gen_nxt;
      active_r     <= active_nxt;
      lease_r      <= lease_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

@@ rtl/vegl_out_reg.sv @@
// Result register with valid/stall handshake.
`timescale 1ns / 1ps

module vegl_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  output logic              load_ready,
  input  vegl_pkg::result_t load_res,
  output logic              out_valid,
  input  logic              out_stall,
  output vegl_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  vegl_pkg::result_t res_r;
  logic              load;

  assign load_ready = ~valid_r | ~out_stall;
  assign load       = load_valid & load_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/vegl_checker.sv @@
// Port-level assertions for the volume event generation lease checker.
`timescale 1ns / 1ps

module vegl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [8:0]  out_assigned_sequence,
  input logic        out_active_now,
  input logic [63:0] out_lease_now
);

  // accepted results carry a nonzero sequence, rejected ones carry zero
  a_seq_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_status == vegl_pkg::ST_ACCEPTED) == (out_assigned_sequence != 9'd0)))
    else $error("sequence number disagrees with status");

  // no lease can be held without an active generation
  a_lease_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active_now) |-> (out_lease_now == 64'd0))
    else $error("lease held while generation inactive");

  // a stalled result stays put until it is taken
  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_assigned_sequence) &&
       $stable(out_active_now) && $stable(out_lease_now)))
    else $error("stalled result changed");

endmodule

bind volume_event_generation_lease_checker vegl_checker u_vegl_checker (.*);
